/* src/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants, codes and types for the sorted table search block.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;            // holds the depth itself
  localparam int PTR_W       = CNT_W + 1;            // signed range bounds (-1 .. depth)

  // Fixed field widths
  localparam int DATA_W      = 32;
  localparam int ENTRY_IDX_W = 10;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int LIM_W       = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  // Interpolation datapath
  localparam int DIFF_W      = DATA_W + 1;           // difference of two entries
  localparam int PROD_W      = PTR_W + DIFF_W;       // span times key offset
  localparam int DIV_CNT_W   = $clog2(PROD_W + 1);

  // Configuration port
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;
  localparam int CFG_ADDR_W  = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_MODE = REG_IDX_W'(1);

  // Operation and mode codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;
  localparam logic MODE_BINARY = 1'b0;
  localparam logic MODE_INTERP = 1'b1;

  // Register file contents seen by the search engine
  typedef struct packed {
    logic [SIZE_W-1:0] table_size;
    logic              search_mode;
  } sts_cfg_t;

  // Divider command and result
  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic signed [DIFF_W-1:0] den;
  } sts_div_cmd_t;

  typedef struct packed {
    logic              done;
    logic              neg;
    logic [PROD_W-1:0] quo;
  } sts_div_res_t;

endpackage

/* src/sts_item_if.sv */
// ----------------------------------------------------------------------------
// sts_item_if
// Input channel: table loads and search requests, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_item_if import sts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [ENTRY_IDX_W-1:0]   entry_index;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] search_key;

  modport source (output valid, op, entry_index, entry_value, search_key, input ready);
  modport sink   (input valid, op, entry_index, entry_value, search_key, output ready);
endinterface

/* src/sts_result_if.sv */
// ----------------------------------------------------------------------------
// sts_result_if
// Output channel: search outcome, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_result_if import sts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

/* src/sts_cfg.sv */
// ----------------------------------------------------------------------------
// sts_cfg
// APB register file holding table size and probe mode.
// ----------------------------------------------------------------------------
module sts_cfg import sts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output sts_cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [SIZE_W-1:0]    table_size;
  logic                 search_mode;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= '0;
      search_mode <= MODE_BINARY;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TABLE_SIZE:  table_size  <= pwdata[SIZE_W-1:0];
        REG_SEARCH_MODE: search_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_TABLE_SIZE:  prdata = APB_DATA_W'(table_size);
      REG_SEARCH_MODE: prdata = APB_DATA_W'(search_mode);
      default:         prdata = '0;
    endcase
  end

  assign cfg.table_size  = table_size;
  assign cfg.search_mode = search_mode;

endmodule

/* src/sts_table_ram.sv */
// ----------------------------------------------------------------------------
// sts_table_ram
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sts_table_ram import sts_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sts_div.sv */
// ----------------------------------------------------------------------------
// sts_div
// Serial signed divider for the interpolation probe: one quotient bit per
// cycle, magnitude of the truncated quotient plus its sign.
// ----------------------------------------------------------------------------
module sts_div import sts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sts_div_cmd_t cmd,
  output sts_div_res_t res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dq;      // dividend shifting out, quotient shifting in
  logic [DIFF_W-1:0]    rem;
  logic [DIFF_W-1:0]    dmag;
  logic                 neg;
  logic [DIFF_W:0]      rem_sh;
  logic [DIFF_W:0]      rem_diff;
  logic                 qbit;

  // trial subtract
  assign rem_sh   = {rem, dq[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dmag};
  assign qbit     = !rem_diff[DIFF_W];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq   <= cmd.num[PROD_W-1] ? PROD_W'(-cmd.num) : PROD_W'(cmd.num);
      dmag <= cmd.den[DIFF_W-1] ? DIFF_W'(-cmd.den) : DIFF_W'(cmd.den);
      rem  <= '0;
      neg  <= cmd.num[PROD_W-1] ^ cmd.den[DIFF_W-1];
    end else if (busy) begin
      rem <= qbit ? rem_diff[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
      dq  <= {dq[PROD_W-2:0], qbit};
    end
  end

  assign res.done = done;
  assign res.neg  = neg;
  assign res.quo  = dq;

endmodule

/* src/sorted_table_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_search
// Ascending table of signed words with binary or interpolation search.
//
//   channel  dir  handshake         word
//   item     in   valid/ready       op, entry_index, entry_value, search_key
//   result   out  valid/ready       found, position
//   apb      in   psel/penable      table_size (0x0), search_mode (0x4)
//
// A load writes the table RAM directly when it is accepted.
// A binary probe computes the midpoint, issues the RAM read and compares
// the read word with the key; at most 11 probes over 1024 entries.
// An interpolation probe adds two end reads, a multiply and a serial divide
// of the PROD_W (45) bit product; the divide is skipped on equal end values.
// One item is worked at a time; item.ready is low while a search runs or its
// word waits behind a stalled result register. Reset is synchronous.
// ----------------------------------------------------------------------------
module sorted_table_search import sts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sts_item_if.sink              item,
  sts_result_if.source          result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_LO_RD  = 10'b0000000100,
    S_HI_RD  = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_DIV_GO = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_ISSUE  = 10'b0010000000,
    S_PROBE  = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  state_t                   state;
  sts_cfg_t                 cfg;
  sts_div_cmd_t             div_cmd;
  sts_div_res_t             div_res;

  logic signed [DATA_W-1:0] key;
  logic signed [PTR_W-1:0]  range_low;
  logic signed [PTR_W-1:0]  range_high;
  logic [IDX_W-1:0]         mid;
  logic signed [DATA_W-1:0] vlo;
  logic signed [DIFF_W-1:0] kdiff;
  logic signed [DIFF_W-1:0] den;
  logic signed [PROD_W-1:0] prod;
  logic                     hit;

  logic                     accept;
  logic                     load_we;
  logic [IDX_W-1:0]         raddr;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] rdata_s;
  logic [LIM_W-1:0]         size_ext;
  logic [LIM_W-1:0]         n_eff;
  logic signed [PTR_W-1:0]  span;
  logic signed [PTR_W-1:0]  mid_s;
  logic signed [PTR_W:0]    bsum;
  logic                     q_ok;
  logic                     out_free;

  // configuration registers
  sts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // table memory
  sts_table_ram u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(item.entry_index)),
    .wdata (item.entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // interpolation divider
  sts_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign load_we    = accept && (item.op == OP_LOAD) &&
                      (32'(item.entry_index) < 32'(TABLE_DEPTH));
  assign out_free   = !result.valid || result.ready;
  assign rdata_s    = signed'(rdata);

  // effective table size, clamped to the depth
  assign size_ext = LIM_W'(cfg.table_size);
  assign n_eff    = (size_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : size_ext;

  // probe arithmetic
  assign span  = range_high - range_low;
  assign mid_s = signed'(PTR_W'(mid));
  assign bsum  = (PTR_W + 1)'(range_low) + (PTR_W + 1)'(range_high);
  assign q_ok  = (div_res.quo == '0) ||
                 (!div_res.neg && (div_res.quo <= PROD_W'(unsigned'(span))));

  // RAM read address by state
  always_comb begin
    case (state)
      S_LO_RD: raddr = range_low[IDX_W-1:0];
      S_HI_RD: raddr = range_high[IDX_W-1:0];
      default: raddr = mid;
    endcase
  end

  // divider command
  assign div_cmd.start = (state == S_DIV_GO) && (den != '0);
  assign div_cmd.num   = prod;
  assign div_cmd.den   = den;

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      range_low  <= '0;
      range_high <= '0;
      hit        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (item.op == OP_SEARCH)) begin
            range_low  <= '0;
            range_high <= PTR_W'(n_eff) - PTR_ONE;
            hit        <= 1'b0;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (range_low > range_high) begin
            state <= S_FINISH;
          end else if (cfg.search_mode == MODE_BINARY) begin
            state <= S_ISSUE;
          end else begin
            state <= S_LO_RD;
          end
        end
        S_LO_RD:  state <= S_HI_RD;
        S_HI_RD:  state <= S_MUL;
        S_MUL:    state <= S_DIV_GO;
        S_DIV_GO: state <= (den == '0) ? S_ISSUE : S_DIV;
        S_DIV: begin
          if (div_res.done) begin
            state <= q_ok ? S_ISSUE : S_FINISH;
          end
        end
        S_ISSUE:  state <= S_PROBE;
        S_PROBE: begin
          if (key == rdata_s) begin
            hit   <= 1'b1;
            state <= S_FINISH;
          end else if (key < rdata_s) begin
            range_high <= mid_s - PTR_ONE;
            state      <= S_CHECK;
          end else begin
            range_low <= mid_s + PTR_ONE;
            state     <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && (item.op == OP_SEARCH)) begin
      key <= item.search_key;
    end
    case (state)
      S_CHECK: begin
        mid <= bsum[IDX_W:1];
      end
      S_HI_RD: begin
        vlo   <= rdata_s;
        kdiff <= DIFF_W'(key) - DIFF_W'(rdata_s);
      end
      S_MUL: begin
        den  <= DIFF_W'(rdata_s) - DIFF_W'(vlo);
        prod <= PROD_W'(span) * PROD_W'(kdiff);
      end
      S_DIV_GO: begin
        mid <= range_low[IDX_W-1:0];
      end
      S_DIV: begin
        if (div_res.done) begin
          mid <= range_low[IDX_W-1:0] + div_res.quo[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      result.found    <= hit;
      result.position <= hit ? POS_W'(mid) : '0;
    end
  end

endmodule

/* dv/tb_sorted_table_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_search
// Self-checking bench for the sorted table search block. A directed table
// covers the empty table, value extremes, equal end values and out-of-range
// interpolation probes. Random phases follow: a full 1024-entry ascending
// table searched in both modes, then many small tables (ascending, duplicate,
// constant, unordered) with loads mixed in. Searches are checked against the
// in-bench model or pinned outcome; register writes are read back over APB.
// ----------------------------------------------------------------------------
module tb_sorted_table_search;
  import sts_pkg::*;

  localparam int     CLK_PERIOD    = 10;
  localparam int     RESET_CYCLES  = 8;
  localparam int     SETTLE_CYCLES = 16;     // a load may still be in flight
  localparam int     HOLD_CYCLES   = 400;    // long result back-pressure
  localparam int     STALL_LIMIT   = 200000; // above the slowest interpolation search
  localparam int     REPORT_MAX    = 10;
  localparam int     DIR_ROWS      = 29;
  localparam longint SPAN_STEP     = 64'sd4294967296 / TABLE_DEPTH;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic                     op;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } table_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } outcome_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_SIZE, ROW_MODE} row_kind_e;

  // pinned rows carry the outcome typed in; others use the search model
  typedef struct packed {
    row_kind_e                kind;
    logic                     op;
    logic [ENTRY_IDX_W-1:0]   idx;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] key;
    logic                     pinned;
    logic                     found;
    logic [POS_W-1:0]         pos;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty table
    '{ROW_SIZE, OP_LOAD,   10'd0,    32'sd0,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_MODE, OP_LOAD,   10'd0,    32'(MODE_BINARY), 32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd0,  1'b1, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MIN, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MAX, 1'b1, 1'b0, 10'd0},
    // five entries spanning the full value range
    '{ROW_ITEM, OP_LOAD,   10'd0,    VAL_MIN,          32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd1,    -32'sd5,          32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd2,    32'sd0,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd3,    32'sd7,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd4,    VAL_MAX,          32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd1023, VAL_MAX,          32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_SIZE, OP_LOAD,   10'd0,    32'sd5,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MIN, 1'b1, 1'b1, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MAX, 1'b1, 1'b1, 10'd4},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd7,  1'b1, 1'b1, 10'd3},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd6,  1'b1, 1'b0, 10'd0},
    // same table, interpolation probes
    '{ROW_MODE, OP_LOAD,   10'd0,    32'(MODE_INTERP), 32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MIN, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           VAL_MAX, 1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           -32'sd4, 1'b0, 1'b0, 10'd0},
    // equal end values: probe falls back to the low end
    '{ROW_SIZE, OP_LOAD,   10'd0,    32'sd2,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd0,    32'sd9,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_LOAD,   10'd1,    32'sd9,           32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd9,  1'b1, 1'b1, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd10, 1'b0, 1'b0, 10'd0},
    // interpolated probe above and below the range
    '{ROW_ITEM, OP_LOAD,   10'd1,    32'sd20,          32'sd0,  1'b0, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           32'sd100, 1'b1, 1'b0, 10'd0},
    '{ROW_ITEM, OP_SEARCH, 10'd0,    32'sd0,           -32'sd50, 1'b1, 1'b0, 10'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sts_item_if   item_ch ();
  sts_result_if result_ch ();

  // search model state
  logic signed [DATA_W-1:0] table_shadow [TABLE_DEPTH];
  logic [SIZE_W-1:0]        size_cfg;
  logic                     mode_cfg;
  logic [SIZE_W-1:0]        bound_low;
  logic [SIZE_W-1:0]        bound_high;
  outcome_t                 pending_outcomes [$];

  int mismatch_count;
  int idle_cycles;
  bit quiet;      // no gaps on either side
  bit hold_req;   // ask the result side for a long hold-off

  sorted_table_search DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endfunction

  // Search as the block does it; updates the range bounds left behind
  function automatic outcome_t search_outcome(input logic signed [DATA_W-1:0] key);
    longint   n, lo, hi, mid, base, den, probe, k;
    outcome_t o;
    o.found    = 1'b0;
    o.position = '0;
    k  = key;
    n  = (size_cfg > TABLE_DEPTH) ? TABLE_DEPTH : size_cfg;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      if (mode_cfg == MODE_BINARY) begin
        mid = (lo + hi) / 2;
      end else begin
        base = table_shadow[lo];
        den  = table_shadow[hi] - base;
        if (den == 0) mid = lo;
        else mid = lo + ((hi - lo) * (k - base)) / den;
        if (mid < lo || mid > hi) break;
      end
      probe = table_shadow[mid];
      if (k == probe) begin
        o.found    = 1'b1;
        o.position = mid[POS_W-1:0];
        break;
      end else if (k < probe) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    bound_low  = lo[SIZE_W-1:0];
    bound_high = hi[SIZE_W-1:0];
    return o;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic table_req_t load_word(input int idx, input logic signed [DATA_W-1:0] v);
    table_req_t w;
    w.op          = OP_LOAD;
    w.entry_index = idx[ENTRY_IDX_W-1:0];
    w.entry_value = v;
    w.search_key  = $urandom;
    return w;
  endfunction

  function automatic table_req_t search_word(input logic signed [DATA_W-1:0] key);
    table_req_t w;
    w.op          = OP_SEARCH;
    w.entry_index = $urandom;
    w.entry_value = $urandom;
    w.search_key  = key;
    return w;
  endfunction

  // Keys: mostly table hits, some near misses, extremes and noise
  function automatic logic signed [DATA_W-1:0] pick_key(input int n);
    int                       r;
    logic signed [DATA_W-1:0] k;
    r = $urandom_range(99);
    k = $urandom;
    if (n > 0 && r < 60) k = table_shadow[$urandom_range(n - 1)];
    else if (n > 0 && r < 70) k = table_shadow[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    else if (r < 78) k = r[0] ? VAL_MAX : VAL_MIN;
    return k;
  endfunction

  // Offer one word after a random gap; model it once accepted
  task automatic offer_word(input table_req_t w, input bit pinned, input outcome_t pinned_exp);
    int       gap;
    outcome_t o;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
    end
    @(negedge clk);
    item_ch.valid       = 1'b1;
    item_ch.op          = w.op;
    item_ch.entry_index = w.entry_index;
    item_ch.entry_value = w.entry_value;
    item_ch.search_key  = w.search_key;
    do @(posedge clk); while (!item_ch.ready);
    if (w.op == OP_LOAD) begin
      table_shadow[w.entry_index] = w.entry_value;
    end else begin
      o = search_outcome(w.search_key);
      pending_outcomes.push_back(pinned ? pinned_exp : o);
    end
  endtask

  // Stop offering until every search word has come back
  task automatic drain_outcomes();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] reg_idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {reg_idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Register write while idle, then read back
  task automatic set_register(input logic [REG_IDX_W-1:0] reg_idx,
                              input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    logic [APB_DATA_W-1:0] want;
    drain_outcomes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, reg_idx, value, readback);
    if (reg_idx == REG_TABLE_SIZE) begin
      size_cfg = value[SIZE_W-1:0];
      want     = APB_DATA_W'(size_cfg);
    end else begin
      mode_cfg = value[0];
      want     = APB_DATA_W'(mode_cfg);
    end
    apb_access(1'b0, reg_idx, '0, readback);
    if (readback !== want) begin
      report_mismatch($sformatf("register %0d read back 0x%0h, expected 0x%0h",
                                reg_idx, readback, want));
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_outcomes
    outcome_t exp_o;
    outcome_t got_o;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got_o.found    = result_ch.found;
      got_o.position = result_ch.position;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected word found=%0b position=%0d",
                                  got_o.found, got_o.position));
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (got_o.found !== exp_o.found || got_o.position !== exp_o.position) begin
          report_mismatch($sformatf("found %0b/%0b position %0d/%0d (actual/expected)",
                                    got_o.found, exp_o.found, got_o.position,
                                    exp_o.position));
        end
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    int burst;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = gap_len();
      if (stall != 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      burst = $urandom_range(1, 24);
      repeat (burst) @(negedge clk);
    end
  end

  initial begin : stimulus
    table_req_t               w;
    outcome_t                 pin;
    dir_row_t                 row;
    int                       n;
    int                       shape;
    longint                   acc;
    logic signed [DATA_W-1:0] prev;

    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item_ch.valid       = 1'b0;
    item_ch.op          = OP_LOAD;
    item_ch.entry_index = '0;
    item_ch.entry_value = '0;
    item_ch.search_key  = '0;
    quiet               = 1'b0;
    hold_req            = 1'b0;
    mismatch_count      = 0;
    size_cfg            = '0;
    mode_cfg            = MODE_BINARY;
    bound_low           = '0;
    bound_high          = '0;
    pin                 = '0;
    prev                = VAL_MIN;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      case (row.kind)
        ROW_SIZE: set_register(REG_TABLE_SIZE, APB_DATA_W'(row.val));
        ROW_MODE: set_register(REG_SEARCH_MODE, APB_DATA_W'(row.val));
        default: begin
          w.op          = row.op;
          w.entry_index = row.idx;
          w.entry_value = row.val;
          w.search_key  = row.key;
          pin.found     = row.found;
          pin.position  = row.pos;
          offer_word(w, row.pinned, pin);
        end
      endcase
    end

    // full ascending table, extremes at both ends, a few duplicates
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) acc = VAL_MIN;
      else if (i == TABLE_DEPTH - 1) acc = VAL_MAX;
      else if ($urandom_range(19) == 0) acc = prev;
      else acc = longint'(VAL_MIN) + longint'(i) * SPAN_STEP + $urandom_range(SPAN_STEP - 1);
      prev = acc[DATA_W-1:0];
      offer_word(load_word(i, prev), 1'b0, pin);
    end

    // searches over the full table and over prefixes of it
    for (int s = 0; s < 5; s++) begin
      n = (s < 2) ? TABLE_DEPTH : ((s == 4) ? 1 : $urandom_range(2, TABLE_DEPTH - 1));
      set_register(REG_TABLE_SIZE, APB_DATA_W'(n));
      set_register(REG_SEARCH_MODE, APB_DATA_W'(s[0] ? MODE_INTERP : MODE_BINARY));
      quiet    = (s == 1);
      hold_req = (s == 0);   // fill the block while results are held off
      for (int k = 0; k < 70; k++) begin
        if (s == 2 && k == 35) drain_outcomes();
        if (s == 4 && $urandom_range(3) == 0)
          offer_word(load_word($urandom_range(1, TABLE_DEPTH - 1), $urandom), 1'b0, pin);
        else
          offer_word(search_word(pick_key(n)), 1'b0, pin);
      end
    end
    quiet = 1'b0;

    // small tables of assorted shapes, loads mixed into the searches
    for (int p = 0; p < 12; p++) begin
      n     = (p == 0) ? 0 : $urandom_range(1, 16);
      shape = $urandom_range(9);
      acc   = longint'($signed($urandom));
      for (int i = 0; i < n; i++) begin
        if (shape <= 5) begin
          if (i > 0) acc += ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
        end else if (shape == 6) begin
          if (i > 0 && $urandom_range(2) == 0) acc += $urandom_range(3);
        end else if (shape == 8) begin
          acc = longint'($signed($urandom));   // unordered
        end else if (shape == 9) begin
          if (i == 0) acc = VAL_MIN;
          else if (i == n - 1) acc = VAL_MAX;
          else acc = longint'(VAL_MIN) + (longint'(i) <<< 32) / n;
        end
        if (acc > VAL_MAX) acc = VAL_MAX;
        offer_word(load_word(i, acc[DATA_W-1:0]), 1'b0, pin);
      end
      set_register(REG_TABLE_SIZE, APB_DATA_W'(n));
      set_register(REG_SEARCH_MODE, APB_DATA_W'($urandom_range(1)));
      quiet = (p == 5);
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(6) == 0)
          offer_word(load_word($urandom_range(TABLE_DEPTH - 1), $urandom), 1'b0, pin);
        else
          offer_word(search_word(pick_key(n)), 1'b0, pin);
      end
      quiet = 1'b0;
    end

    drain_outcomes();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sts_pkg.sv
src/sts_item_if.sv
src/sts_result_if.sv
src/sts_cfg.sv
src/sts_table_ram.sv
src/sts_div.sv
src/sorted_table_search.sv
dv/tb_sorted_table_search.sv
